// ===== rtl/ccr_pkg.sv =====
package ccr_pkg;

  // Table geometry and coordinate format
  localparam int MAX_POINTS = 16;
  localparam int COORD_BITS = 16;
  localparam int IDX_W      = $clog2(MAX_POINTS);
  localparam int CNT_W      = $clog2(MAX_POINTS + 1);
  localparam int NUM_TAPS   = 4;

  // Fixed field widths
  localparam int PC_W  = 5;
  localparam int T_W   = 16;
  localparam int OUT_W = 24;

  // Working widths: coefficients and Horner partials fit in COORD_BITS+6
  localparam int WW  = COORD_BITS + 6;
  localparam int PRW = WW + T_W + 1;
  localparam int SW  = (WW > OUT_W) ? WW : OUT_W;

  // Command queue between front and back
  localparam int Q_DEPTH = 4;
  localparam int QP_W    = $clog2(Q_DEPTH);
  localparam int QC_W    = $clog2(Q_DEPTH + 1);

  // Result buffer, sized to cover the back-end pipeline
  localparam int OUT_DEPTH = 8;
  localparam int OP_W      = $clog2(OUT_DEPTH);
  localparam int OC_W      = $clog2(OUT_DEPTH + 1);

  localparam logic [PC_W-1:0] PC_RESET = PC_W'(5);

  typedef enum logic {
    OP_LOAD = 1'b0,
    OP_EVAL = 1'b1
  } op_e;

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic signed [WW-1:0]         wk_t;
  typedef logic signed [PRW-1:0]        prod_t;
  typedef logic signed [SW-1:0]         satw_t;
  typedef logic signed [OUT_W-1:0]      out_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
    coord_t z;
  } point_t;

  typedef struct packed {
    logic                             is_eval;
    logic [IDX_W-1:0]                 wr_idx;
    point_t                           pt;
    logic [NUM_TAPS-1:0][IDX_W-1:0]   rd_idx;
    logic [T_W-1:0]                   t;
  } cmd_t;

  typedef struct packed {
    out_t pos_x;
    out_t pos_y;
    out_t pos_z;
    out_t deriv_x;
    out_t deriv_y;
    out_t deriv_z;
  } res_t;

  localparam prod_t RND_HALF = PRW'(32768);
  localparam satw_t OUT_MAX  = SW'(8388607);
  localparam satw_t OUT_MIN  = -SW'(8388608);

  // a * t with t taken as unsigned Q0.16
  function automatic prod_t mul_t16(input wk_t a, input logic [T_W-1:0] t);
    logic signed [T_W:0] ts;
    ts = $signed({1'b0, t});
    return a * ts;
  endfunction

  // Round half up and drop 16 fraction bits
  function automatic wk_t rnd16(input prod_t v);
    prod_t r;
    r = (v + RND_HALF) >>> 16;
    return WW'(r);
  endfunction

  // Halve (round half up) and clamp to the result range
  function automatic out_t half_sat(input wk_t v);
    satw_t e;
    satw_t h;
    e = SW'(v);
    h = (e + SW'(1)) >>> 1;
    if (h > OUT_MAX) begin
      h = OUT_MAX;
    end else if (h < OUT_MIN) begin
      h = OUT_MIN;
    end
    return OUT_W'(h);
  endfunction

endpackage

// ===== rtl/closed_catmull_rom_eval.sv =====
// Closed-loop uniform Catmull-Rom evaluator.
// Input channel (push/full): each beat carries op plus all fields. A load beat
// (op 0) writes one control point into the 16-entry table and gives no result;
// an evaluate beat (op 1) gives one result with position and derivative per
// axis, signed Q24.0 (integer point units), saturated to 24 bits. Results leave in input order.
// Result channel (empty/pop): the oldest result sits on the ports while empty
// is low and is taken at an edge with pop high.
// Config: cfg_we_i writes the loop length; write it only while the block is idle.
// Path: an accepted beat is queued, issued to the table, runs a five-stage
// arithmetic pipe and lands in the result buffer, from which it can be popped.
// Throughput is one beat per cycle, loads and evaluates alike, while evaluates have
// result-buffer credit; it is set by the single-issue back end and its table read.
// A stalled receiver first fills the eight-entry result buffer; issue of
// evaluates then holds, the four-entry command queue fills and full rises.
// Reset: the loop length returns to 5, queue and buffer empty. Table contents
// are not cleared; evaluate only over points that were loaded.
module closed_catmull_rom_eval (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [ccr_pkg::PC_W-1:0]        cfg_wdata_i,
  input  logic                            push,
  output logic                            full,
  input  logic                            op_i,
  input  logic [3:0]                      point_index_i,
  input  logic signed [15:0]              point_x_i,
  input  logic signed [15:0]              point_y_i,
  input  logic signed [15:0]              point_z_i,
  input  logic [15:0]                     curve_param_i,
  output logic                            empty,
  input  logic                            pop,
  output logic signed [ccr_pkg::OUT_W-1:0] pos_x_o,
  output logic signed [ccr_pkg::OUT_W-1:0] pos_y_o,
  output logic signed [ccr_pkg::OUT_W-1:0] pos_z_o,
  output logic signed [ccr_pkg::OUT_W-1:0] deriv_x_o,
  output logic signed [ccr_pkg::OUT_W-1:0] deriv_y_o,
  output logic signed [ccr_pkg::OUT_W-1:0] deriv_z_o
);
  import ccr_pkg::*;

  logic accept;
  logic fr_push;
  cmd_t fr_cmd;
  cmd_t q_cmd;
  logic q_empty;
  logic q_pop;
  res_t res;

  assign accept = push && !full;

  // front: config register, segment/tap indices, drop of out-of-table loads
  ccr_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .accept_i     (accept),
    .op_i         (op_i),
    .point_index_i(point_index_i),
    .point_x_i    (point_x_i),
    .point_y_i    (point_y_i),
    .point_z_i    (point_z_i),
    .curve_param_i(curve_param_i),
    .push_o       (fr_push),
    .cmd_o        (fr_cmd)
  );

  // command queue decoupling front from back
  ccr_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (fr_push),
    .cmd_i  (fr_cmd),
    .full_o (full),
    .pop_i  (q_pop),
    .cmd_o  (q_cmd),
    .empty_o(q_empty)
  );

  // back: table copies, arithmetic pipe, result buffer
  ccr_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (q_cmd),
    .cmd_valid_i(!q_empty),
    .cmd_pop_o  (q_pop),
    .pop_i      (pop),
    .empty_o    (empty),
    .res_o      (res)
  );

  assign pos_x_o   = res.pos_x;
  assign pos_y_o   = res.pos_y;
  assign pos_z_o   = res.pos_z;
  assign deriv_x_o = res.deriv_x;
  assign deriv_y_o = res.deriv_y;
  assign deriv_z_o = res.deriv_z;

endmodule

// ===== rtl/ccr_front.sv =====
module ccr_front (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  logic [ccr_pkg::PC_W-1:0] cfg_wdata_i,
  input  logic                    accept_i,
  input  logic                    op_i,
  input  logic [3:0]              point_index_i,
  input  logic signed [15:0]      point_x_i,
  input  logic signed [15:0]      point_y_i,
  input  logic signed [15:0]      point_z_i,
  input  logic [15:0]             curve_param_i,
  output logic                    push_o,
  output ccr_pkg::cmd_t           cmd_o
);
  import ccr_pkg::*;

  localparam int S_W = T_W + CNT_W;

  logic [PC_W-1:0]  pc_q;
  logic [CNT_W-1:0] n;
  logic [S_W-1:0]   s;
  logic [CNT_W-1:0] seg, seg_p1, i0, i2, i3;
  logic             in_range;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= PC_RESET;
    end else if (cfg_we_i) begin
      pc_q <= cfg_wdata_i;
    end
  end

  // Effective loop length: zero acts as one, clamp to table size
  always_comb begin
    if (pc_q == '0) begin
      n = CNT_W'(1);
    end else if (int'(pc_q) > MAX_POINTS) begin
      n = CNT_W'(MAX_POINTS);
    end else begin
      n = CNT_W'(pc_q);
    end
  end

  // u < 1, so the integer part is already below n
  assign s      = S_W'(curve_param_i) * S_W'(n);
  assign seg    = s[S_W-1:T_W];
  assign seg_p1 = seg + CNT_W'(1);

  always_comb begin
    i0 = (seg == '0) ? (n - CNT_W'(1)) : (seg - CNT_W'(1));
    i2 = (seg_p1 == n) ? '0 : seg_p1;
    i3 = ((i2 + CNT_W'(1)) == n) ? '0 : (i2 + CNT_W'(1));
  end

  assign in_range = int'(point_index_i) < MAX_POINTS;

  always_comb begin
    cmd_o           = '0;
    cmd_o.is_eval   = (op_i == OP_EVAL);
    cmd_o.wr_idx    = IDX_W'(point_index_i);
    cmd_o.pt.x      = COORD_BITS'(point_x_i);
    cmd_o.pt.y      = COORD_BITS'(point_y_i);
    cmd_o.pt.z      = COORD_BITS'(point_z_i);
    cmd_o.rd_idx[0] = IDX_W'(i0);
    cmd_o.rd_idx[1] = IDX_W'(seg);
    cmd_o.rd_idx[2] = IDX_W'(i2);
    cmd_o.rd_idx[3] = IDX_W'(i3);
    cmd_o.t         = s[T_W-1:0];
  end

  // Loads outside the table are dropped here
  assign push_o = accept_i && ((op_i == OP_EVAL) || in_range);

endmodule

// ===== rtl/ccr_queue.sv =====
module ccr_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  ccr_pkg::cmd_t cmd_i,
  output logic          full_o,
  input  logic          pop_i,
  output ccr_pkg::cmd_t cmd_o,
  output logic          empty_o
);
  import ccr_pkg::*;

  cmd_t            mem_q [Q_DEPTH];
  logic [QP_W-1:0] wr_q, rd_q;
  logic [QC_W-1:0] cnt_q;

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= wr_q + QP_W'(1);
      end
      if (pop_i) begin
        rd_q <= rd_q + QP_W'(1);
      end
      cnt_q <= cnt_q + QC_W'(push_i) - QC_W'(pop_i);
    end
  end

  assign cmd_o   = mem_q[rd_q];
  assign full_o  = (cnt_q == QC_W'(Q_DEPTH));
  assign empty_o = (cnt_q == '0);

endmodule

// ===== rtl/ccr_axis.sv =====
module ccr_axis (
  input  logic                      clk_i,
  input  ccr_pkg::coord_t           p0_i,
  input  ccr_pkg::coord_t           p1_i,
  input  ccr_pkg::coord_t           p2_i,
  input  ccr_pkg::coord_t           p3_i,
  input  logic [ccr_pkg::T_W-1:0]   t_i,
  output ccr_pkg::out_t             pos_o,
  output ccr_pkg::out_t             deriv_o
);
  import ccr_pkg::*;

  wk_t e0, e1, e2, e3, a0, a1, h1, d1, h2, d2, h3;

  // stage 2: doubled basis coefficients
  wk_t a0_q, a0x3_q, a1_q, a2_q, a3_q;
  logic [T_W-1:0] t2_q;
  // stage 3: first products
  prod_t pm_q, qm_q;
  wk_t s3_a1_q, s3_a2_q, s3_a3_q;
  logic [T_W-1:0] t3_q;
  // stage 4
  prod_t pm2_q, qm2_q;
  wk_t s4_a2_q, s4_a3_q;
  logic [T_W-1:0] t4_q;
  // stage 5
  prod_t pm3_q;
  wk_t s5_a3_q;
  out_t deriv5_q;
  // stage 6
  out_t pos6_q, deriv6_q;

  assign e0 = WW'(p0_i);
  assign e1 = WW'(p1_i);
  assign e2 = WW'(p2_i);
  assign e3 = WW'(p3_i);
  assign a0 = e3 - e0 + (e1 <<< 1) + e1 - (e2 <<< 1) - e2;
  assign a1 = (e0 <<< 1) - (e1 <<< 2) - e1 + (e2 <<< 2) - e3;

  assign h1 = rnd16(pm_q) + s3_a1_q;
  assign d1 = rnd16(qm_q) + (s3_a1_q <<< 1);
  assign h2 = rnd16(pm2_q) + s4_a2_q;
  assign d2 = rnd16(qm2_q) + s4_a2_q;
  assign h3 = rnd16(pm3_q) + s5_a3_q;

  always_ff @(posedge clk_i) begin
    a0_q     <= a0;
    a0x3_q   <= (a0 <<< 1) + a0;
    a1_q     <= a1;
    a2_q     <= e2 - e0;
    a3_q     <= e1 <<< 1;
    t2_q     <= t_i;

    pm_q     <= mul_t16(a0_q, t2_q);
    qm_q     <= mul_t16(a0x3_q, t2_q);
    s3_a1_q  <= a1_q;
    s3_a2_q  <= a2_q;
    s3_a3_q  <= a3_q;
    t3_q     <= t2_q;

    pm2_q    <= mul_t16(h1, t3_q);
    qm2_q    <= mul_t16(d1, t3_q);
    s4_a2_q  <= s3_a2_q;
    s4_a3_q  <= s3_a3_q;
    t4_q     <= t3_q;

    pm3_q    <= mul_t16(h2, t4_q);
    s5_a3_q  <= s4_a3_q;
    deriv5_q <= half_sat(d2);

    pos6_q   <= half_sat(h3);
    deriv6_q <= deriv5_q;
  end

  assign pos_o   = pos6_q;
  assign deriv_o = deriv6_q;

endmodule

// ===== rtl/ccr_back.sv =====
module ccr_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  ccr_pkg::cmd_t cmd_i,
  input  logic          cmd_valid_i,
  output logic          cmd_pop_o,
  input  logic          pop_i,
  output logic          empty_o,
  output ccr_pkg::res_t res_o
);
  import ccr_pkg::*;

  localparam int LAT = 6;

  logic            issue_eval, issue_load, take;
  logic [OC_W-1:0] credit_q, credit_d;
  logic [LAT-1:0]  v_q;
  logic [T_W-1:0]  t1_q;
  point_t          rd_data [NUM_TAPS];
  res_t            wres;
  res_t            obuf_q [OUT_DEPTH];
  logic [OP_W-1:0] owr_q, ord_q;
  logic [OC_W-1:0] ocnt_q;

  // Credits cover items in flight plus those parked in the buffer
  assign issue_eval = cmd_valid_i && cmd_i.is_eval && (credit_q < OC_W'(OUT_DEPTH));
  assign issue_load = cmd_valid_i && !cmd_i.is_eval;
  assign cmd_pop_o  = issue_eval || issue_load;
  assign take       = pop_i && !empty_o;
  assign credit_d   = credit_q + OC_W'(issue_eval) - OC_W'(take);

  // One copy of the table per tap, all written together
  for (genvar k = 0; k < NUM_TAPS; k++) begin : g_copy
    point_t mem_q [MAX_POINTS];
    point_t rd_q;
    always_ff @(posedge clk_i) begin
      if (issue_load) begin
        mem_q[cmd_i.wr_idx] <= cmd_i.pt;
      end
      if (issue_eval) begin
        rd_q <= mem_q[cmd_i.rd_idx[k]];
      end
    end
    assign rd_data[k] = rd_q;
  end

  always_ff @(posedge clk_i) begin
    if (issue_eval) begin
      t1_q <= cmd_i.t;
    end
  end

  ccr_axis u_ax_x (
    .clk_i  (clk_i),
    .p0_i   (rd_data[0].x),
    .p1_i   (rd_data[1].x),
    .p2_i   (rd_data[2].x),
    .p3_i   (rd_data[3].x),
    .t_i    (t1_q),
    .pos_o  (wres.pos_x),
    .deriv_o(wres.deriv_x)
  );

  ccr_axis u_ax_y (
    .clk_i  (clk_i),
    .p0_i   (rd_data[0].y),
    .p1_i   (rd_data[1].y),
    .p2_i   (rd_data[2].y),
    .p3_i   (rd_data[3].y),
    .t_i    (t1_q),
    .pos_o  (wres.pos_y),
    .deriv_o(wres.deriv_y)
  );

  ccr_axis u_ax_z (
    .clk_i  (clk_i),
    .p0_i   (rd_data[0].z),
    .p1_i   (rd_data[1].z),
    .p2_i   (rd_data[2].z),
    .p3_i   (rd_data[3].z),
    .t_i    (t1_q),
    .pos_o  (wres.pos_z),
    .deriv_o(wres.deriv_z)
  );

  always_ff @(posedge clk_i) begin
    if (v_q[LAT-1]) begin
      obuf_q[owr_q] <= wres;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      credit_q <= '0;
      v_q      <= '0;
      owr_q    <= '0;
      ord_q    <= '0;
      ocnt_q   <= '0;
    end else begin
      credit_q <= credit_d;
      v_q      <= {v_q[LAT-2:0], issue_eval};
      if (v_q[LAT-1]) begin
        owr_q <= owr_q + OP_W'(1);
      end
      if (take) begin
        ord_q <= ord_q + OP_W'(1);
      end
      ocnt_q <= ocnt_q + OC_W'(v_q[LAT-1]) - OC_W'(take);
    end
  end

  assign empty_o = (ocnt_q == '0);
  assign res_o   = obuf_q[ord_q];

  a_credit_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    credit_q <= OC_W'(OUT_DEPTH))
    else $error("credit count above buffer depth");

  a_buf_in_credit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ocnt_q <= credit_q)
    else $error("buffered results not covered by credits");

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_q[LAT-1] |-> (ocnt_q < OC_W'(OUT_DEPTH)))
    else $error("result written into a full buffer");

  a_load_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    issue_load |=> !v_q[0])
    else $error("load beat started an evaluation");

endmodule

// ===== bench/tb_top.sv =====
// Tracks the control-point table and the loop length on the bench side and
// keeps the samples that are still owed, oldest first.
class spline_scoreboard;
  ccr_pkg::point_t          ctrl_pts[ccr_pkg::MAX_POINTS];
  logic [ccr_pkg::PC_W-1:0] loop_len;
  ccr_pkg::res_t            awaited[$];
  int                       mismatches;
  int                       loads_seen;
  int                       checked;

  function new();
    loop_len   = ccr_pkg::PC_RESET;
    mismatches = 0;
    loads_seen = 0;
    checked    = 0;
  endfunction

  function void set_count(logic [ccr_pkg::PC_W-1:0] v);
    loop_len = v;
  endfunction

  // Points actually in the loop: zero acts as one, anything past the table as full
  function int span();
    if (loop_len == 0) begin
      return 1;
    end
    if (loop_len > ccr_pkg::MAX_POINTS) begin
      return ccr_pkg::MAX_POINTS;
    end
    return int'(loop_len);
  endfunction

  function int pending();
    return awaited.size();
  endfunction

  function longint coord_of(ccr_pkg::point_t pt, int ax);
    case (ax)
      0: begin
        return longint'(pt.x);
      end
      1: begin
        return longint'(pt.y);
      end
      default: begin
        return longint'(pt.z);
      end
    endcase
  endfunction

  // Q0.16 product back to integer, round half up (>>> floors on signed)
  function longint round_q16(longint v);
    return (v + 32768) >>> 16;
  endfunction

  function ccr_pkg::out_t halve_clamp(longint v);
    longint h;
    h = (v + 1) >>> 1;
    if (h > 8388607) begin
      h = 8388607;
    end else if (h < -8388608) begin
      h = -8388608;
    end
    return h[23:0];
  endfunction

  // Position and d/dt of the uniform segment picked by u, all three axes
  function ccr_pkg::res_t predict(logic [15:0] u);
    ccr_pkg::res_t r;
    ccr_pkg::out_t pos[3];
    ccr_pkg::out_t der[3];
    int            n;
    int            s;
    int            seg;
    int            tap[4];
    longint        t;
    longint        p[4];
    longint        a0;
    longint        a1;
    longint        a2;
    longint        a3;
    longint        h;
    longint        d;
    n      = span();
    s      = int'(u) * n;
    seg    = (s >>> 16) % n;
    t      = longint'(s & 32'h0000_FFFF);
    tap[0] = (seg + n - 1) % n;
    for (int i = 1; i < 4; i++) begin
      tap[i] = (tap[i-1] + 1) % n;
    end
    for (int ax = 0; ax < 3; ax++) begin
      for (int i = 0; i < 4; i++) begin
        p[i] = coord_of(ctrl_pts[tap[i]], ax);
      end
      // doubled basis coefficients
      a0 = -p[0] + 3 * p[1] - 3 * p[2] + p[3];
      a1 = 2 * p[0] - 5 * p[1] + 4 * p[2] - p[3];
      a2 = p[2] - p[0];
      a3 = 2 * p[1];
      h  = round_q16(a0 * t) + a1;
      h  = round_q16(h * t) + a2;
      h  = round_q16(h * t) + a3;
      d  = round_q16(3 * a0 * t) + 2 * a1;
      d  = round_q16(d * t) + a2;
      pos[ax] = halve_clamp(h);
      der[ax] = halve_clamp(d);
    end
    r.pos_x   = pos[0];
    r.pos_y   = pos[1];
    r.pos_z   = pos[2];
    r.deriv_x = der[0];
    r.deriv_y = der[1];
    r.deriv_z = der[2];
    return r;
  endfunction

  function void note_beat(ccr_pkg::op_e op, logic [3:0] idx, ccr_pkg::point_t pt,
                          logic [15:0] u);
    if (op == ccr_pkg::OP_LOAD) begin
      ctrl_pts[idx] = pt;
      loads_seen++;
    end else begin
      awaited.push_back(predict(u));
    end
  endfunction

  task report(string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    mismatches++;
  endtask

  task compare(string name, ccr_pkg::out_t got, ccr_pkg::out_t want);
    if (got !== want) begin
      report($sformatf("sample %0d %s got %0d want %0d", checked, name, got, want));
    end
  endtask

  task check_result(ccr_pkg::res_t got);
    ccr_pkg::res_t want;
    if (awaited.size() == 0) begin
      report("result beat with no sample outstanding");
      return;
    end
    want = awaited.pop_front();
    checked++;
    compare("pos_x", got.pos_x, want.pos_x);
    compare("pos_y", got.pos_y, want.pos_y);
    compare("pos_z", got.pos_z, want.pos_z);
    compare("deriv_x", got.deriv_x, want.deriv_x);
    compare("deriv_y", got.deriv_y, want.deriv_y);
    compare("deriv_z", got.deriv_z, want.deriv_z);
  endtask
endclass

module tb_top;
  import ccr_pkg::*;

  // All DUT inputs start at known values
  logic               clk_i         = 1'b0;
  logic               rst_ni        = 1'b0;
  logic               cfg_we_i      = 1'b0;
  logic [PC_W-1:0]    cfg_wdata_i   = '0;
  logic               push          = 1'b0;
  logic               op_i          = 1'b0;
  logic [3:0]         point_index_i = '0;
  logic signed [15:0] point_x_i     = '0;
  logic signed [15:0] point_y_i     = '0;
  logic signed [15:0] point_z_i     = '0;
  logic [15:0]        curve_param_i = '0;
  logic               pop           = 1'b0;
  logic               full;
  logic               empty;
  out_t               pos_x_o;
  out_t               pos_y_o;
  out_t               pos_z_o;
  out_t               deriv_x_o;
  out_t               deriv_y_o;
  out_t               deriv_z_o;

  spline_scoreboard spline_sb;

  // steady: neither side idles. hold_req bumps ask the receiver for a long stall.
  logic steady      = 1'b0;
  int   hold_req    = 0;
  int   hold_seen   = 0;
  int   hold_left   = 0;
  int   full_stalls = 0;
  int   lens_used   = 1;

  closed_catmull_rom_eval dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .push         (push),
    .full         (full),
    .op_i         (op_i),
    .point_index_i(point_index_i),
    .point_x_i    (point_x_i),
    .point_y_i    (point_y_i),
    .point_z_i    (point_z_i),
    .curve_param_i(curve_param_i),
    .empty        (empty),
    .pop          (pop),
    .pos_x_o      (pos_x_o),
    .pos_y_o      (pos_y_o),
    .pos_z_o      (pos_z_o),
    .deriv_x_o    (deriv_x_o),
    .deriv_y_o    (deriv_y_o),
    .deriv_z_o    (deriv_z_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Hard stop well past the slowest legal run (~1200 beats, stalls, drains)
  initial begin
    #2000000;
    $display("Regression FAIL");
    $finish;
  end

  // Receiver: a beat leaves at an edge with pop high and empty low, so the
  // pre-edge values seen here are the ones the handshake used.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        spline_sb.check_result('{pos_x: pos_x_o, pos_y: pos_y_o, pos_z: pos_z_o,
                                 deriv_x: deriv_x_o, deriv_y: deriv_y_o,
                                 deriv_z: deriv_z_o});
      end
      if (hold_req != hold_seen) begin
        hold_seen = hold_req;
        hold_left = 150;
      end
      if (hold_left > 0) begin
        hold_left--;
        pop <= 1'b0;
      end else begin
        pop <= steady || ($urandom_range(99) >= 31);
      end
    end
  end

  // One input beat: random gap first, then hold push until full is low at an edge
  task automatic send_beat(op_e op, logic [3:0] idx, point_t pt, logic [15:0] u);
    while (!steady && $urandom_range(99) < 31) begin
      push <= 1'b0;
      @(posedge clk_i);
    end
    push          <= 1'b1;
    op_i          <= op;
    point_index_i <= idx;
    point_x_i     <= pt.x;
    point_y_i     <= pt.y;
    point_z_i     <= pt.z;
    curve_param_i <= u;
    @(posedge clk_i);
    while (full) begin
      full_stalls++;
      @(posedge clk_i);
    end
    spline_sb.note_beat(op, idx, pt, u);
  endtask

  // Drain everything owed, then let loads still in the queue retire
  task automatic drain_all();
    push <= 1'b0;
    while (spline_sb.pending() != 0) begin
      @(posedge clk_i);
    end
    repeat (12) @(posedge clk_i);
  endtask

  task automatic set_loop_len(logic [PC_W-1:0] v);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    spline_sb.set_count(v);
    lens_used++;
  endtask

  function automatic logic [15:0] rand_coord();
    case ($urandom_range(9))
      0: begin
        return 16'sh7FFF;
      end
      1: begin
        return 16'sh8000;
      end
      2: begin
        return 16'(0 - $urandom_range(1));
      end
      default: begin
        return 16'($urandom_range(65535));
      end
    endcase
  endfunction

  // Random beat: ~30 % loads; parameters lean on 0, the top and segment seams
  task automatic send_random_beat();
    point_t      pt;
    logic [15:0] u;
    int          n;
    int          k;
    int          pick;
    op_e         op;
    n    = spline_sb.span();
    pt.x = rand_coord();
    pt.y = rand_coord();
    pt.z = rand_coord();
    pick = $urandom_range(99);
    if (pick < 10) begin
      u = 16'h0000;
    end else if (pick < 20) begin
      u = 16'hFFFF;
    end else if (pick < 35) begin
      k = $urandom_range(n - 1);
      u = 16'((k * 65536 + n - 1) / n - int'($urandom_range(1)));
    end else begin
      u = 16'($urandom_range(65535));
    end
    op = ($urandom_range(99) < 30) ? OP_LOAD : OP_EVAL;
    send_beat(op, 4'($urandom_range(15)), pt, u);
  endtask

  initial begin
    logic [PC_W-1:0] lens[8];
    logic [15:0]     seams[6];
    point_t          pt;
    spline_sb = new();
    lens      = '{5'd16, 5'd0, 5'd1, 5'd31, 5'd17, 5'd2, 5'd9, 5'd5};
    lens[6]   = 5'($urandom_range(31));
    seams     = '{16'd0, 16'd1, 16'd13107, 16'd13108, 16'd32768, 16'hFFFF};

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: fill the whole table first so no evaluate can touch an
    // unwritten entry; x swings rail to rail between neighbours.
    for (int k = 0; k < MAX_POINTS; k++) begin
      pt.x = (k % 2 != 0) ? 16'sh7FFF : 16'sh8000;
      pt.y = 16'(k * 4369 - 32768);
      case (k % 4)
        0: begin
          pt.z = 16'sh0000;
        end
        1: begin
          pt.z = 16'shFFFF;
        end
        2: begin
          pt.z = 16'sh5555;
        end
        default: begin
          pt.z = 16'shAAAA;
        end
      endcase
      send_beat(OP_LOAD, 4'(k), pt, 16'(k));
    end
    // reset loop length of five: ends of the range and both sides of a seam
    for (int i = 0; i < 6; i++) begin
      send_beat(OP_EVAL, 4'(i), pt, seams[i]);
    end
    drain_all();

    // Random phases, each under its own loop length. Phase 1 stalls the
    // receiver long enough to back the block up into full; phase 2 runs
    // with no idling on either side.
    for (int ph = 0; ph < 8; ph++) begin
      set_loop_len(lens[ph]);
      steady <= (ph == 1 || ph == 2);
      if (ph == 1) begin
        hold_req <= hold_req + 1;
      end
      for (int i = 0; i < 140; i++) begin
        send_random_beat();
      end
      drain_all();
      steady <= 1'b0;
    end

    // Tail: nothing owed, then extra cycles to catch a stray result beat
    repeat (20) @(posedge clk_i);
    $display("covered %0d load beats and %0d checked samples over %0d loop lengths",
             spline_sb.loads_seen, spline_sb.checked, lens_used);
    $display("input held off by full for %0d cycles; %0d mismatches",
             full_stalls, spline_sb.mismatches);
    if (spline_sb.mismatches == 0 && spline_sb.pending() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end
endmodule
